// ===== design/i2a_pkg.sv =====
package i2a_pkg;

   localparam int MAX_CHARS  = 23;
   localparam int DIGIT_W    = 4;
   localparam int STORE_W    = MAX_CHARS * DIGIT_W;
   localparam int VALUE_W    = 64;
   localparam int DEC_DIGITS = 20;
   localparam int OCT_DIGITS = 22;
   localparam int HEX_DIGITS = 16;
   localparam int COUNT_W    = 5;

   localparam logic [1:0] MODE_DEC = 2'd0;
   localparam logic [1:0] MODE_OCT = 2'd1;
   localparam logic [1:0] MODE_HEX = 2'd2;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] HEX_OFFSET  = 8'd87;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;

   typedef enum logic [2:0] {
      RADIX_DEC = 3'b001,
      RADIX_OCT = 3'b010,
      RADIX_HEX = 3'b100
   } radix_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  mode;
      logic        signed_decimal;
      logic        alternate_octal;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] magnitude;
      radix_type   radix;
      logic        negative;
      logic        prefix;
   } job_type;

endpackage

// ===== design/i2a_front.sv =====
module i2a_front (
   input  i2a_pkg::req_type req_data,
   output i2a_pkg::job_type job
);

   always_comb begin
      job.magnitude = req_data.value;
      job.negative  = 1'b0;
      job.prefix    = 1'b0;
      job.radix     = i2a_pkg::RADIX_HEX;
      if (req_data.signed_decimal) begin
         job.radix    = i2a_pkg::RADIX_DEC;
         job.negative = req_data.value[63];
         if (req_data.value[63]) begin
            job.magnitude = 64'd0 - req_data.value;
         end
      end else begin
         unique case (req_data.mode)
            i2a_pkg::MODE_DEC: job.radix = i2a_pkg::RADIX_DEC;
            i2a_pkg::MODE_OCT: job.radix = i2a_pkg::RADIX_OCT;
            default:           job.radix = i2a_pkg::RADIX_HEX;
         endcase
         job.prefix = (req_data.mode == i2a_pkg::MODE_OCT) && req_data.alternate_octal
                      && (req_data.value != 64'd0);
      end
   end

endmodule

// ===== design/i2a_queue.sv =====
module i2a_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  i2a_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output i2a_pkg::job_type pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2a_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/i2a_back.sv =====
module i2a_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  i2a_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2a_pkg::rsp_type rsp_data
);

   localparam int SW         = i2a_pkg::STORE_W;
   localparam int DW         = i2a_pkg::DIGIT_W;
   localparam int BCD_W      = i2a_pkg::DEC_DIGITS * DW;
   localparam int CONV_STEPS = i2a_pkg::VALUE_W / 2;
   localparam int STEP_W     = $clog2(CONV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [SW-1:0]                 digits_ff, digits_in;
   logic [i2a_pkg::VALUE_W-1:0]   bin_ff, bin_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [i2a_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          sign_ff, sign_in;
   logic                          prefix_ff, prefix_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   i2a_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic                          out_free;
   logic [DW-1:0]                 top_digit;
   logic [BCD_W-1:0]              bcd_next;
   logic [SW-1:0]                 oct_digits;
   logic [SW-1:0]                 hex_digits;
   logic [i2a_pkg::VALUE_W+1:0]   mag_ext;

   // one shift-and-add-3 step of binary to bcd
   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                               input logic           bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
         if (bcd[i*DW +: DW] >= 4'd5) begin
            adj[i*DW +: DW] = bcd[i*DW +: DW] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   function automatic logic [7:0] digit_char(input logic [DW-1:0] d);
      if (d > i2a_pkg::DIGIT_MAX) begin
         return {4'd0, d} + i2a_pkg::HEX_OFFSET;
      end
      return {4'd0, d} + i2a_pkg::CHAR_ZERO;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign top_digit = digits_ff[SW-1 -: DW];
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign mag_ext   = {2'b00, job.magnitude};
   assign bcd_next  = dabble(dabble(digits_ff[BCD_W-1:0], bin_ff[63]), bin_ff[62]);

   always_comb begin
      oct_digits = '0;
      hex_digits = '0;
      for (int i = 0; i < i2a_pkg::OCT_DIGITS; i++) begin
         oct_digits[i*DW +: DW] = {1'b0, mag_ext[i*3 +: 3]};
      end
      for (int i = 0; i < i2a_pkg::HEX_DIGITS; i++) begin
         hex_digits[i*DW +: DW] = job.magnitude[i*DW +: DW];
      end
   end

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sign_in      = sign_ff;
      prefix_in    = prefix_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               sign_in   = job.negative;
               prefix_in = job.prefix;
               count_in  = i2a_pkg::COUNT_W'(i2a_pkg::MAX_CHARS);
               bin_in    = job.magnitude;
               step_in   = STEP_W'(CONV_STEPS - 1);
               unique case (job.radix)
                  i2a_pkg::RADIX_DEC: begin
                     digits_in = '0;
                     state_in  = ST_CONV;
                  end
                  i2a_pkg::RADIX_OCT: begin
                     digits_in = oct_digits;
                     state_in  = ST_SKIP;
                  end
                  default: begin
                     digits_in = hex_digits;
                     state_in  = ST_SKIP;
                  end
               endcase
            end
         end
         ST_CONV: begin
            digits_in = {{(SW - BCD_W){1'b0}}, bcd_next};
            bin_in    = {bin_ff[i2a_pkg::VALUE_W-3:0], 2'b00};
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((count_ff > 5'd1) && (top_digit == '0)) begin
               digits_in = {digits_ff[SW-DW-1:0], {DW{1'b0}}};
               count_in  = count_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_data_in.character = i2a_pkg::CHAR_MINUS;
                  rsp_data_in.last      = 1'b0;
                  sign_in               = 1'b0;
               end else if (prefix_ff) begin
                  rsp_data_in.character = i2a_pkg::CHAR_ZERO;
                  rsp_data_in.last      = 1'b0;
                  prefix_in             = 1'b0;
               end else begin
                  rsp_data_in.character = digit_char(top_digit);
                  rsp_data_in.last      = (count_ff == 5'd1);
                  digits_in             = {digits_ff[SW-DW-1:0], {DW{1'b0}}};
                  count_in              = count_ff - 1'b1;
                  if (count_ff == 5'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sign_ff      <= 1'b0;
         prefix_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sign_ff      <= sign_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      bin_ff      <= bin_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/integer_to_ascii_radix.sv =====
// Converts a 64-bit value to ASCII text in decimal, octal or lowercase hex, one
// character per rsp transaction, most significant first, with last on the final
// digit. A front stage classifies each req transaction (radix, sign, magnitude,
// octal prefix) into a QUEUE_DEPTH-entry queue; a back engine converts and emits.
// Per item the back engine loads the job, then for decimal does binary-to-bcd
// shifting (two bits a cycle), then drops leading zero digits one at a time from
// the 23-digit field, then sends one character per cycle unless rsp is stalled.
// The back engine works one item at a time; the front keeps accepting while the
// queue has room.
module integer_to_ascii_radix #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2a_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2a_pkg::rsp_type rsp_data
);

   i2a_pkg::job_type front_job;
   i2a_pkg::job_type back_job;
   logic             queue_full;
   logic             queue_empty;
   logic             queue_pop;

   assign req_stall = queue_full;

   i2a_front u_front (
      .req_data (req_data),
      .job      (front_job)
   );

   i2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !queue_full),
      .push_data (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (back_job),
      .empty     (queue_empty)
   );

   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job       (back_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
